>>> rtl/assert_macros.svh
// Assertion macros used by the box blur top level.
// Expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every cycle outside reset
`define BBR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// pre in one cycle implies post in the next
`define BBR_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/bbr_pkg.sv
// Box blur package: payload types, register map and fixed constants.
// No dependencies.
`timescale 1ns / 1ps
package bbr_pkg;

  localparam int PIX_W    = 24;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 12;
  localparam int GAIN_W   = 20;
  localparam int QDEPTH   = 8;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int OCC_W    = $clog2(QDEPTH + 1);
  localparam int ADDR_W   = 4;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_GAIN   = 2'd2;

  localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 11'd128;
  localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 12'd128;
  localparam logic [GAIN_W-1:0]   RST_GAIN   = 20'd26214;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pixel_rgb;
  } bbr_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] blurred_rgb;
    logic             last_of_frame;
  } bbr_out_t;

  typedef struct packed {
    logic             valid;
    logic             interior;
    logic             last;
    logic [PIX_W-1:0] fwd;
  } bbr_tap_t;

endpackage

>>> rtl/bbr_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps
module bbr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> rtl/bbr_ctrl.sv
// Raster position tracking, line store addressing and output scheduling.
// Depends on bbr_pkg.
`timescale 1ns / 1ps
module bbr_ctrl #(
  parameter int RADIUS    = 2,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  input  logic                                          in_stall,
  input  bbr_pkg::bbr_in_t                              in_data,
  input  logic                                          geom_clr,
  input  logic [$clog2(MAX_WIDTH):0]                    eff_w,
  input  logic [bbr_pkg::HEIGHT_W-1:0]                  eff_h,
  input  logic [$clog2(MAX_WIDTH)+bbr_pkg::HEIGHT_W:0]  lag,
  input  logic [$clog2(MAX_WIDTH)+bbr_pkg::HEIGHT_W:0]  total,
  output logic                                          emit,
  output logic                                          wr_en,
  output logic [$clog2(2*RADIUS+1)-1:0]                 wr_slot,
  output logic [$clog2(MAX_WIDTH)-1:0]                  wr_col,
  output logic [bbr_pkg::PIX_W-1:0]                     wr_data,
  output logic [$clog2(MAX_WIDTH)-1:0]                  rd_b_col,
  output bbr_pkg::bbr_tap_t                             tap_r,
  output logic [$clog2(2*RADIUS+1)-1:0]                 fwd_slot_r,
  output logic [$clog2(2*RADIUS+1)-1:0]                 ctr_slot_r
);
  import bbr_pkg::*;

  localparam int WIN_SIDE = 2 * RADIUS + 1;
  localparam int SLOTW    = $clog2(WIN_SIDE);
  localparam int COLW     = $clog2(MAX_WIDTH);
  localparam int WBITS    = COLW + 1;
  localparam int POSW     = WBITS + HEIGHT_W;

  logic [COLW-1:0]     in_col_r, in_col_nxt;
  logic [SLOTW-1:0]    in_slot_r, in_slot_nxt;
  logic [POSW-1:0]     rx_cnt_r, rx_cnt_nxt;
  logic [POSW-1:0]     out_pos_r, out_pos_nxt;
  logic [COLW-1:0]     out_col_r, out_col_nxt;
  logic [HEIGHT_W-1:0] out_row_r, out_row_nxt;
  logic [SLOTW-1:0]    out_slot_r, out_slot_nxt;

  logic              accept, complete, emit_px, emit_fl, last, interior;
  logic [WBITS-1:0]  in_col_inc, out_col_inc;
  logic [WBITS:0]    col_hi;
  logic [HEIGHT_W:0] row_hi;

  assign accept   = in_valid && !in_stall;
  assign complete = (rx_cnt_r == total);
  assign wr_en    = accept && (in_data.cmd == CMD_PIXEL) && !complete;
  assign emit_px  = wr_en && (rx_cnt_r >= lag);
  assign emit_fl  = accept && (in_data.cmd == CMD_FLUSH) && complete && (out_pos_r < total);
  assign emit     = emit_px || emit_fl;

  assign wr_slot  = in_slot_r;
  assign wr_col   = in_col_r;
  assign wr_data  = in_data.pixel_rgb;
  assign rd_b_col = out_col_r;

  assign in_col_inc  = {1'b0, in_col_r} + WBITS'(1);
  assign out_col_inc = {1'b0, out_col_r} + WBITS'(1);
  assign col_hi      = {2'b00, out_col_r} + (WBITS + 1)'(RADIUS);
  assign row_hi      = {1'b0, out_row_r} + (HEIGHT_W + 1)'(RADIUS);
  assign last        = ({1'b0, out_pos_r} + (POSW + 1)'(1)) >= {1'b0, total};
  assign interior    = (out_row_r >= HEIGHT_W'(RADIUS)) && (row_hi < {1'b0, eff_h}) &&
                       ({1'b0, out_col_r} >= WBITS'(RADIUS)) && (col_hi < {1'b0, eff_w});

  always_comb begin
    in_col_nxt   = in_col_r;
    in_slot_nxt  = in_slot_r;
    rx_cnt_nxt   = rx_cnt_r;
    out_pos_nxt  = out_pos_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_slot_nxt = out_slot_r;
    if (wr_en) begin
      rx_cnt_nxt = rx_cnt_r + POSW'(1);
      if (in_col_inc >= eff_w) begin
        in_col_nxt  = '0;
        in_slot_nxt = (in_slot_r == SLOTW'(WIN_SIDE - 1)) ? '0 : in_slot_r + SLOTW'(1);
      end else begin
        in_col_nxt = in_col_inc[COLW-1:0];
      end
    end
    if (emit) begin
      out_pos_nxt = out_pos_r + POSW'(1);
      if (out_col_inc >= eff_w) begin
        out_col_nxt  = '0;
        out_row_nxt  = out_row_r + HEIGHT_W'(1);
        out_slot_nxt = (out_slot_r == SLOTW'(WIN_SIDE - 1)) ? '0 : out_slot_r + SLOTW'(1);
      end else begin
        out_col_nxt = out_col_inc[COLW-1:0];
      end
    end
    if ((emit && last) || geom_clr) begin
      in_col_nxt   = '0;
      in_slot_nxt  = '0;
      rx_cnt_nxt   = '0;
      out_pos_nxt  = '0;
      out_col_nxt  = '0;
      out_row_nxt  = '0;
      out_slot_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r    <= '0;
      in_slot_r   <= '0;
      rx_cnt_r    <= '0;
      out_pos_r   <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_slot_r  <= '0;
      tap_r.valid <= 1'b0;
    end else begin
      in_col_r    <= in_col_nxt;
      in_slot_r   <= in_slot_nxt;
      rx_cnt_r    <= rx_cnt_nxt;
      out_pos_r   <= out_pos_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
      out_slot_r  <= out_slot_nxt;
      tap_r.valid <= emit;
    end
    tap_r.interior <= interior;
    tap_r.last     <= last;
    tap_r.fwd      <= in_data.pixel_rgb;
    fwd_slot_r     <= in_slot_r;
    ctr_slot_r     <= out_slot_r;
  end

endmodule

>>> rtl/bbr_filter.sv
// Window column sums, sliding total, gain multiply, saturation and edge pass-through.
// Depends on bbr_pkg.
`timescale 1ns / 1ps
module bbr_filter #(
  parameter int RADIUS = 2
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  bbr_pkg::bbr_tap_t                         tap,
  input  logic [$clog2(2*RADIUS+1)-1:0]             fwd_slot,
  input  logic [$clog2(2*RADIUS+1)-1:0]             ctr_slot,
  input  logic [(2*RADIUS+1)*bbr_pkg::PIX_W-1:0]    rd_a,
  input  logic [(2*RADIUS+1)*bbr_pkg::PIX_W-1:0]    rd_b,
  input  logic [bbr_pkg::GAIN_W-1:0]                gain,
  output logic                                      res_v_r,
  output bbr_pkg::bbr_out_t                         res_r
);
  import bbr_pkg::*;

  localparam int WIN_SIDE = 2 * RADIUS + 1;
  localparam int SLOTW    = $clog2(WIN_SIDE);
  localparam int CSW      = $clog2(WIN_SIDE * 255 + 1);
  localparam int TW       = $clog2(WIN_SIDE * WIN_SIDE * 255 + 1);
  localparam int PW       = TW + GAIN_W;

  logic [CSW-1:0]   cs_new [3];
  logic [CSW-1:0]   cs_r   [WIN_SIDE][3];
  logic [TW-1:0]    tot    [3];
  logic [TW-1:0]    tot_r  [3];
  logic [PW-1:0]    prod_r [3];
  logic [PIX_W-1:0] center, px, blur;
  logic [PIX_W-1:0] ctr2_r, ctr3_r, ctr4_r;
  logic             v2_r, v3_r, v4_r;
  logic             int2_r, int3_r, int4_r;
  logic             last2_r, last3_r, last4_r;
  logic [PW-17:0]   scaled [3];

  always_comb begin
    center = '0;
    for (int c = 0; c < 3; c++) begin
      cs_new[c] = '0;
    end
    for (int i = 0; i < WIN_SIDE; i++) begin
      px = (SLOTW'(i) == fwd_slot) ? tap.fwd : rd_a[i*PIX_W +: PIX_W];
      for (int c = 0; c < 3; c++) begin
        cs_new[c] = cs_new[c] + CSW'(px[c*8 +: 8]);
      end
      if (SLOTW'(i) == ctr_slot) begin
        center = rd_b[i*PIX_W +: PIX_W];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tot[c] = '0;
      for (int i = 0; i < WIN_SIDE; i++) begin
        tot[c] = tot[c] + TW'(cs_r[i][c]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      scaled[c] = prod_r[c][PW-1:16];
      blur[c*8 +: 8] = (|scaled[c][PW-17:8]) ? 8'hFF : scaled[c][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      v2_r    <= tap.valid;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      res_v_r <= v4_r;
    end
    if (tap.valid) begin
      for (int c = 0; c < 3; c++) begin
        cs_r[0][c] <= cs_new[c];
        for (int i = 1; i < WIN_SIDE; i++) begin
          cs_r[i][c] <= cs_r[i-1][c];
        end
      end
    end
    int2_r  <= tap.interior;
    last2_r <= tap.last;
    ctr2_r  <= center;
    for (int c = 0; c < 3; c++) begin
      tot_r[c]  <= tot[c];
      prod_r[c] <= PW'(tot_r[c]) * PW'(gain);
    end
    int3_r  <= int2_r;
    last3_r <= last2_r;
    ctr3_r  <= ctr2_r;
    int4_r  <= int3_r;
    last4_r <= last3_r;
    ctr4_r  <= ctr3_r;
    res_r.blurred_rgb   <= int4_r ? blur : ctr4_r;
    res_r.last_of_frame <= last4_r;
  end

endmodule

>>> rtl/bbr_outq.sv
// Output queue that absorbs results while the sink stalls.
// Depends on bbr_pkg.
`timescale 1ns / 1ps
module bbr_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bbr_pkg::bbr_out_t push_data,
  input  logic              out_stall,
  output logic              out_valid,
  output bbr_pkg::bbr_out_t out_data
);
  import bbr_pkg::*;

  bbr_out_t          q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OCC_W-1:0]  cnt_r;
  logic              pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = q_mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + OCC_W'(push) - OCC_W'(pop);
    end
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/rgb_box_blur.sv
// Streaming RGB box blur top level: configuration registers, line store banks,
// output credit. Depends on bbr_pkg, bbr_ram, bbr_ctrl, bbr_filter, bbr_outq.
//
// Accepts one transaction (pixel or flush) per clock, sustained, as long as fewer
// than eight results are held between the pipeline and the output queue. The line
// store is split into 2*RADIUS+1 row banks, each with one write port and two read
// ports: one read gathers the new window column, the other fetches the pixel for
// edge pass-through, so a transaction costs at most one write and two reads per
// bank in a single cycle. A result passes the tap register, the filter's column
// sum, total, product and result registers and the output queue; the results of
// a frame trail their pixels by RADIUS rows plus RADIUS pixels, and the tail is
// drained by flush transactions once the whole frame is in. Geometry writes restart
// the frame via registered geometry. The line store needs no clearing after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rgb_box_blur #(
  parameter int RADIUS    = 2,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  bbr_pkg::bbr_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output bbr_pkg::bbr_out_t            out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bbr_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import bbr_pkg::*;

  localparam int WIN_SIDE = 2 * RADIUS + 1;
  localparam int SLOTW    = $clog2(WIN_SIDE);
  localparam int COLW     = $clog2(MAX_WIDTH);
  localparam int WBITS    = COLW + 1;
  localparam int POSW     = WBITS + HEIGHT_W;
  localparam int CMPW     = (WBITS > WIDTH_W) ? WBITS : WIDTH_W;
  localparam int RST_EFFW = (int'(RST_WIDTH) > MAX_WIDTH) ? MAX_WIDTH : int'(RST_WIDTH);

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [GAIN_W-1:0]   gain_r;
  logic [WBITS-1:0]    effw_r, effw;
  logic [HEIGHT_W-1:0] effh_r, effh;
  logic [POSW-1:0]     lag_r, total_r;
  logic                cfg_wr, geom_clr;
  logic [1:0]          reg_idx;

  logic [OCC_W-1:0]    occ_r;
  logic                emit, pop;

  logic                  wr_en;
  logic [SLOTW-1:0]      wr_slot, fwd_slot, ctr_slot;
  logic [COLW-1:0]       wr_col, rd_b_col;
  logic [PIX_W-1:0]      wr_data;
  logic [WIN_SIDE*PIX_W-1:0] rd_a, rd_b;
  bbr_tap_t              tap;
  logic                  res_v;
  bbr_out_t              res;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[3:2];
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign geom_clr = cfg_wr && ((reg_idx == REG_WIDTH) || (reg_idx == REG_HEIGHT));

  always_comb begin
    case (reg_idx)
      REG_WIDTH:  prdata = 32'(width_r);
      REG_HEIGHT: prdata = 32'(height_r);
      REG_GAIN:   prdata = 32'(gain_r);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    if (width_r == '0) begin
      effw = WBITS'(1);
    end else if (CMPW'(width_r) > CMPW'(MAX_WIDTH)) begin
      effw = WBITS'(MAX_WIDTH);
    end else begin
      effw = WBITS'(width_r);
    end
    effh = (height_r == '0) ? HEIGHT_W'(1) : height_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      gain_r   <= RST_GAIN;
      effw_r   <= WBITS'(RST_EFFW);
      effh_r   <= RST_HEIGHT;
      lag_r    <= POSW'(RADIUS * RST_EFFW + RADIUS);
      total_r  <= POSW'(RST_EFFW * int'(RST_HEIGHT));
      occ_r    <= '0;
    end else begin
      if (cfg_wr) begin
        case (reg_idx)
          REG_WIDTH:  width_r  <= pwdata[WIDTH_W-1:0];
          REG_HEIGHT: height_r <= pwdata[HEIGHT_W-1:0];
          REG_GAIN:   gain_r   <= pwdata[GAIN_W-1:0];
          default:    ;
        endcase
      end
      effw_r  <= effw;
      effh_r  <= effh;
      lag_r   <= POSW'(effw) * POSW'(RADIUS) + POSW'(RADIUS);
      total_r <= POSW'(effw) * POSW'(effh);
      occ_r   <= occ_r + OCC_W'(emit) - OCC_W'(pop);
    end
  end

  assign in_stall = (occ_r >= OCC_W'(QDEPTH));
  assign pop      = out_valid && !out_stall;

  bbr_ctrl #(
    .RADIUS    (RADIUS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .geom_clr   (geom_clr),
    .eff_w      (effw_r),
    .eff_h      (effh_r),
    .lag        (lag_r),
    .total      (total_r),
    .emit       (emit),
    .wr_en      (wr_en),
    .wr_slot    (wr_slot),
    .wr_col     (wr_col),
    .wr_data    (wr_data),
    .rd_b_col   (rd_b_col),
    .tap_r      (tap),
    .fwd_slot_r (fwd_slot),
    .ctr_slot_r (ctr_slot)
  );

  for (genvar i = 0; i < WIN_SIDE; i++) begin : g_bank
    bbr_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_bank (
      .clk     (clk),
      .we      (wr_en && (wr_slot == SLOTW'(i))),
      .waddr   (wr_col),
      .wdata   (wr_data),
      .raddr_a (wr_col),
      .rdata_a (rd_a[i*PIX_W +: PIX_W]),
      .raddr_b (rd_b_col),
      .rdata_b (rd_b[i*PIX_W +: PIX_W])
    );
  end

  bbr_filter #(
    .RADIUS (RADIUS)
  ) u_filter (
    .clk      (clk),
    .rst_n    (rst_n),
    .tap      (tap),
    .fwd_slot (fwd_slot),
    .ctr_slot (ctr_slot),
    .rd_a     (rd_a),
    .rd_b     (rd_b),
    .gain     (gain_r),
    .res_v_r  (res_v),
    .res_r    (res)
  );

  bbr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_v),
    .push_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `BBR_ASSERT(a_occ_bound, occ_r <= OCC_W'(QDEPTH), "result credit overrun")
  `BBR_ASSERT(a_out_has_credit, !out_valid || (occ_r != '0), "output without credit")
  `BBR_ASSERT_NEXT(a_emit_counted, emit && !pop, occ_r != '0, "emitted result not counted")

endmodule
